// ----- rtl/grm_pkg.sv -----
package grm_pkg;

  localparam int MAX_GRID = 1024;
  localparam int LG_GRID  = $clog2(MAX_GRID);
  localparam int ADDR_W   = 2 * LG_GRID;
  localparam int ROWS_W   = 11;
  localparam int CELL_W   = 8;
  localparam int FIELD_W  = 12;
  localparam int COORD_W  = FIELD_W + 1;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int ERR_W    = PROD_W + 2;

  localparam int STRIDE_MID_ABOVE  = 500;
  localparam int STRIDE_HIGH_ABOVE = 1000;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TRACE = 2'd2;

  localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'd126;
  localparam logic [CELL_W-1:0] CELL_FREE    = 8'd255;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [FIELD_W-1:0] x_a;
    logic signed [FIELD_W-1:0] y_a;
    logic signed [FIELD_W-1:0] x_b;
    logic signed [FIELD_W-1:0] y_b;
    logic [CELL_W-1:0]         value;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_value;
    logic              hit_painted;
  } rsp_t;

  typedef struct packed {
    coord_t xh;
    coord_t yh;
    coord_t xs;
    coord_t ys;
    coord_t side;
  } walk_cmd_t;

  typedef struct packed {
    logic   act;
    logic   fin;
    coord_t x;
    coord_t y;
  } walk_stat_t;

  function automatic coord_t ext(input logic signed [FIELD_W-1:0] v);
    return coord_t'(v);
  endfunction

  function automatic logic strict_inside(input coord_t x, input coord_t y, input coord_t side);
    return (x > 0) && (y > 0) && (x < side) && (y < side);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y);
    return {y[LG_GRID-1:0], x[LG_GRID-1:0]};
  endfunction

endpackage

// ----- rtl/grm_grid_ram.sv -----
module grm_grid_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/grm_ray_walker.sv -----
module grm_ray_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  grm_pkg::walk_cmd_t     cmd,
  output grm_pkg::walk_stat_t    stat
);

  localparam logic [2:0] W_IDLE  = 3'd0;
  localparam logic [2:0] W_SETUP = 3'd1;
  localparam logic [2:0] W_MUL1  = 3'd2;
  localparam logic [2:0] W_MUL2  = 3'd3;
  localparam logic [2:0] W_MUL3  = 3'd4;
  localparam logic [2:0] W_VERT  = 3'd5;
  localparam logic [2:0] W_SLOPE = 3'd6;
  localparam logic [2:0] W_FIN   = 3'd7;

  logic [2:0] state, state_next;

  grm_pkg::walk_cmd_t cmd_q;
  grm_pkg::coord_t lo_x, hi_x, lo_y, hi_y, dx, dy;
  grm_pkg::coord_t i, j, j0, xend, yend, cur_y;
  grm_pkg::coord_t row_off, col_off, sx_step, sy_step, i_next, j_next;
  grm_pkg::prod_t  p1, p2;
  grm_pkg::err_t   e, e_row, dj, di, adx;
  logic vert, stride_mid, stride_hi, keep, j_wrap;

  function automatic grm_pkg::coord_t range_low(input grm_pkg::coord_t a,
                                                input grm_pkg::coord_t b);
    if (a <= 0 || b <= 0) begin
      return '0;
    end
    return (a < b) ? a : b;
  endfunction

  function automatic grm_pkg::coord_t range_high(input grm_pkg::coord_t a,
                                                 input grm_pkg::coord_t b,
                                                 input grm_pkg::coord_t r);
    if (a > r || b > r) begin
      return r;
    end
    return (a > b) ? a : b;
  endfunction

  assign sx_step = stride_hi ? grm_pkg::coord_t'(3) :
                   (stride_mid ? grm_pkg::coord_t'(2) : grm_pkg::coord_t'(1));
  assign sy_step = stride_mid ? grm_pkg::coord_t'(2) : grm_pkg::coord_t'(1);
  assign row_off = lo_y + grm_pkg::coord_t'(1) - cmd_q.yh;
  assign col_off = i - cmd_q.xh;
  assign i_next  = i + sx_step;
  assign j_next  = j + sy_step;
  assign j_wrap  = !(j_next < yend);
  assign keep    = (e <= adx) && (e >= -adx);

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE:  if (start) state_next = W_SETUP;
      W_SETUP: state_next = W_MUL1;
      W_MUL1: begin
        if (vert) begin
          state_next = (hi_y > lo_y) ? W_VERT : W_FIN;
        end else begin
          state_next = W_MUL2;
        end
      end
      W_MUL2:  state_next = (i < xend && j < yend) ? W_MUL3 : W_FIN;
      W_MUL3:  state_next = W_SLOPE;
      W_VERT:  if (cur_y - grm_pkg::coord_t'(1) <= lo_y) state_next = W_FIN;
      W_SLOPE: if (j_wrap && !(i_next < xend)) state_next = W_FIN;
      W_FIN:   state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (start) cmd_q <= cmd;
      end
      W_SETUP: begin
        lo_x       <= range_low(cmd_q.xs, cmd_q.xh);
        hi_x       <= range_high(cmd_q.xs, cmd_q.xh, cmd_q.side);
        lo_y       <= range_low(cmd_q.ys, cmd_q.yh);
        hi_y       <= range_high(cmd_q.ys, cmd_q.yh, cmd_q.side);
        dx         <= cmd_q.xs - cmd_q.xh;
        dy         <= cmd_q.ys - cmd_q.yh;
        vert       <= (cmd_q.xs == cmd_q.xh);
        stride_mid <= (cmd_q.side > grm_pkg::coord_t'(grm_pkg::STRIDE_MID_ABOVE));
        stride_hi  <= (cmd_q.side > grm_pkg::coord_t'(grm_pkg::STRIDE_HIGH_ABOVE));
      end
      W_MUL1: begin
        i     <= lo_x + grm_pkg::coord_t'(1);
        j     <= lo_y + grm_pkg::coord_t'(1);
        j0    <= lo_y + grm_pkg::coord_t'(1);
        xend  <= hi_x - grm_pkg::coord_t'(1);
        yend  <= hi_y - grm_pkg::coord_t'(1);
        cur_y <= hi_y;
        p1    <= grm_pkg::prod_t'(row_off) * grm_pkg::prod_t'(dx);
        adx   <= (dx < 0) ? -grm_pkg::err_t'(dx) : grm_pkg::err_t'(dx);
        dj    <= stride_mid ? (grm_pkg::err_t'(dx) <<< 1) : grm_pkg::err_t'(dx);
        if (stride_hi) begin
          di <= grm_pkg::err_t'(dy) + (grm_pkg::err_t'(dy) <<< 1);
        end else if (stride_mid) begin
          di <= grm_pkg::err_t'(dy) <<< 1;
        end else begin
          di <= grm_pkg::err_t'(dy);
        end
      end
      W_MUL2: begin
        p2 <= grm_pkg::prod_t'(dy) * grm_pkg::prod_t'(col_off);
      end
      W_MUL3: begin
        e     <= grm_pkg::err_t'(p1) - grm_pkg::err_t'(p2);
        e_row <= grm_pkg::err_t'(p1) - grm_pkg::err_t'(p2);
      end
      W_VERT: begin
        cur_y <= cur_y - grm_pkg::coord_t'(1);
      end
      W_SLOPE: begin
        if (j_wrap) begin
          i     <= i_next;
          j     <= j0;
          e     <= e_row - di;
          e_row <= e_row - di;
        end else begin
          j <= j_next;
          e <= e + dj;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.fin = (state == W_FIN);
  assign stat.x   = vert ? cmd_q.xs : i;
  assign stat.y   = vert ? cur_y : j;
  assign stat.act = ((state == W_VERT) || ((state == W_SLOPE) && keep)) &&
                    grm_pkg::strict_inside(stat.x, stat.y, cmd_q.side);

  a_act_in_visit: assert property (@(posedge clk) disable iff (rst)
    stat.act |-> (state == W_VERT || state == W_SLOPE))
    else $error("walker visit outside a scan state");

  a_slope_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == W_SLOPE) |-> (i < xend && j < yend))
    else $error("sloped scan left its box");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == W_IDLE)
    else $error("walker started while active");

endmodule

// ----- rtl/grid_ray_free_marker_unit.sv -----
// Occupancy grid with ray tracing over a 1M x 8-bit cell memory.
// Requests enter on req when start is high and busy is low; op selects a cell
// write, a cell read or a ray trace. Each request gives one result on rsp,
// shown for exactly one cycle with done high; the receiver cannot stall it.
// Write and read pass a memory state and then a response state before done
// rises; the unused op code goes straight to the response state. busy falls
// with done, so the next request is accepted at the edge that ends the done
// cycle at the earliest. Trace: the hit cell is read and then painted, the
// walker sets up a sloped scan (two registered multiplies seed the line error)
// or a column walk, steps one cell per cycle through a read-modify-write on
// the memory, then closes the walk, and the result is registered.
// A column walk visits hi - lo rows; a sloped scan visits
// ceil((xhi - xlo - 2) / sx) * ceil((yhi - ylo - 2) / sy) cells, which for a
// 1024 side is at most about 174k cells. The single read port of the grid
// memory sets that one-cell-per-cycle rate.
// grid_rows is written on cfg_data with cfg_valid/cfg_ready; ready is high
// whenever the block is idle. Reset sets grid_rows to 1024 and returns to
// idle; the cell memory is not cleared and holds garbage until written.
module grid_ray_free_marker_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  grm_pkg::req_t               req,
  output logic                        done,
  output grm_pkg::rsp_t               rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [grm_pkg::ROWS_W-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MEM      = 3'd1;
  localparam logic [2:0] S_PAINT_RD = 3'd2;
  localparam logic [2:0] S_PAINT_WR = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0] state, state_next;
  logic [grm_pkg::ROWS_W-1:0] grid_rows;
  logic [grm_pkg::COORD_W-1:0] rows_ext;
  grm_pkg::req_t req_q;
  grm_pkg::coord_t side, xa, ya, xb, yb;
  logic cell_in, hit_in, painted, pend;
  logic [grm_pkg::ADDR_W-1:0] a_addr, pend_addr;

  logic                        we, re;
  logic [grm_pkg::ADDR_W-1:0]  waddr, raddr;
  logic [grm_pkg::CELL_W-1:0]  wdata, rdata;

  grm_pkg::walk_cmd_t  walk_cmd;
  grm_pkg::walk_stat_t walk;

  assign rows_ext = {{(grm_pkg::COORD_W - grm_pkg::ROWS_W){1'b0}}, grid_rows};
  assign side = ($signed(rows_ext) > grm_pkg::coord_t'(grm_pkg::MAX_GRID)) ?
                grm_pkg::coord_t'(grm_pkg::MAX_GRID) : $signed(rows_ext);

  assign xa = grm_pkg::ext(req_q.x_a);
  assign ya = grm_pkg::ext(req_q.y_a);
  assign xb = grm_pkg::ext(req_q.x_b);
  assign yb = grm_pkg::ext(req_q.y_b);
  assign cell_in = (xa >= 0) && (ya >= 0) && (xa < side) && (ya < side);
  assign hit_in  = grm_pkg::strict_inside(xa, ya, side);
  assign a_addr  = grm_pkg::cell_addr(xa, ya);

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.op)
            grm_pkg::OP_WRITE, grm_pkg::OP_READ: state_next = S_MEM;
            grm_pkg::OP_TRACE:                   state_next = S_PAINT_RD;
            default:                             state_next = S_RESP;
          endcase
        end
      end
      S_MEM:      state_next = S_RESP;
      S_PAINT_RD: state_next = S_PAINT_WR;
      S_PAINT_WR: state_next = S_SCAN;
      S_SCAN:     if (walk.fin) state_next = S_RESP;
      S_RESP:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = a_addr;
    wdata = req_q.value;
    if (pend && rdata == grm_pkg::CELL_UNKNOWN) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = grm_pkg::CELL_FREE;
    end else if (state == S_MEM && req_q.op == grm_pkg::OP_WRITE && cell_in) begin
      we = 1'b1;
    end else if (state == S_PAINT_WR && hit_in && rdata != '0) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = a_addr;
    if (state == S_MEM && req_q.op == grm_pkg::OP_READ && cell_in) begin
      re = 1'b1;
    end else if (state == S_PAINT_RD && hit_in) begin
      re = 1'b1;
    end else if (state == S_SCAN && walk.act) begin
      re    = 1'b1;
      raddr = grm_pkg::cell_addr(walk.x, walk.y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grid_rows <= grm_pkg::ROWS_W'(grm_pkg::MAX_GRID);
      pend      <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SCAN) && walk.act;
      done  <= (state == S_RESP);
      if (cfg_valid && cfg_ready) begin
        grid_rows <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q   <= req;
      painted <= 1'b0;
    end
    if (state == S_PAINT_WR) begin
      painted <= hit_in && (rdata != '0);
    end
    pend_addr <= raddr;
    if (state == S_RESP) begin
      rsp.read_value  <= (req_q.op == grm_pkg::OP_READ && cell_in) ? rdata : '0;
      rsp.hit_painted <= (req_q.op == grm_pkg::OP_TRACE) && painted;
    end
  end

  assign walk_cmd.xh   = xa;
  assign walk_cmd.yh   = ya;
  assign walk_cmd.xs   = xb;
  assign walk_cmd.ys   = yb;
  assign walk_cmd.side = side;

  grm_ray_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_PAINT_WR),
    .cmd   (walk_cmd),
    .stat  (walk)
  );

  grm_grid_ram #(
    .DATA_W (grm_pkg::CELL_W),
    .ADDR_W (grm_pkg::ADDR_W)
  ) u_grid_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_SCAN)
    else $error("pending cell update outside a scan");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule
